[src/lkx_pkg.sv]
// Shared types and constants for the LCG keystream XOR cipher.
// No dependencies; used by every module in src.
`timescale 1ns / 1ps

package lkx_pkg;

  localparam int WORD_W    = 64;
  localparam int HALF_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 4;
  localparam int STEP_W    = 6;   // remainder step counter, counts 63 down to 0

  localparam logic [BYTE_W-1:0] PAD_MASK = 8'hFF;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED       = 4'd0,
    REG_MULTIPLIER = 4'd1,
    REG_INCREMENT  = 4'd2,
    REG_MODULUS    = 4'd3
  } cfg_reg_t;

  // One queued input item
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last;
  } item_t;

  // Generator settings seen by the back end
  typedef struct packed {
    logic [WORD_W-1:0] seed;
    logic [WORD_W-1:0] multiplier;
    logic [WORD_W-1:0] increment;
    logic [WORD_W-1:0] modulus;
  } cfg_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LL,
    ST_MUL_LH,
    ST_MUL_HL,
    ST_ADD,
    ST_INC,
    ST_DIV,
    ST_FINISH
  } state_t;

endpackage

[src/lcg_keystream_xor_cipher.sv]
// Top level of the LCG keystream XOR cipher: configuration registers, front and back end.
// Depends on lkx_pkg, lkx_front and lkx_back.
`timescale 1ns / 1ps

// Each input beat carries one message byte; the output beat is that byte XORed with the
// low eight bits of the next generator value ((multiplier * value + increment) mod 2^64)
// mod modulus. The first byte of a message steps from the seed; a beat with tlast set
// ends the message. In the back end a byte is loaded, takes three products on the shared
// 32x32 multiplier and two adds, then 64 steps of the bit-serial remainder unit, and is
// handed to the output register once that is free. With a modulus of zero the remainder
// unit is skipped. The input side queues up to QUEUE_DEPTH beats while a byte is in work
// or a result waits. Write the registers only while no byte is in flight; cfg_ready is
// always high and writes to unknown indexes are dropped.

module lcg_keystream_xor_cipher #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lkx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lkx_pkg::WORD_W-1:0]    cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lkx_pkg::BYTE_W-1:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic                          s_axis_tlast,   // last_in
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lkx_pkg::BYTE_W-1:0]    m_axis_tdata,   // [7:0] result_byte
  output logic                          m_axis_tlast    // last_out
);

  lkx_pkg::cfg_t  cfg;
  lkx_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seed       <= '0;
      cfg.multiplier <= '0;
      cfg.increment  <= '0;
      cfg.modulus    <= lkx_pkg::WORD_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lkx_pkg::REG_SEED:       cfg.seed       <= cfg_data;
        lkx_pkg::REG_MULTIPLIER: cfg.multiplier <= cfg_data;
        lkx_pkg::REG_INCREMENT:  cfg.increment  <= cfg_data;
        lkx_pkg::REG_MODULUS:    cfg.modulus    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lkx_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  lkx_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .cfg           (cfg),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[src/lkx_front.sv]
// Front end of the LCG keystream XOR cipher: accepts input beats into a short queue.
// Depends on lkx_pkg (item_t, BYTE_W).
`timescale 1ns / 1ps

module lkx_front #(
  parameter int DEPTH = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [lkx_pkg::BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
  input  logic                      s_axis_tlast,
  output logic                      q_valid,
  output lkx_pkg::item_t            q_item,
  input  logic                      q_pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lkx_pkg::item_t     slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign s_axis_tready = (count != CNT_W'(DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != '0);
  assign pop           = q_pop && q_valid;
  assign q_item        = slots[rd_ptr];

  // Store accepted beats
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].data_byte <= s_axis_tdata;
      slots[wr_ptr].last      <= s_axis_tlast;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_push_only: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a push");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not follow a pop");

endmodule

[src/lkx_back.sv]
// Back end of the LCG keystream XOR cipher: generator step and output register.
// Depends on lkx_pkg (item_t, cfg_t, state_t, widths).
`timescale 1ns / 1ps

module lkx_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  lkx_pkg::item_t             q_item,
  output logic                       q_pop,
  input  lkx_pkg::cfg_t              cfg,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [lkx_pkg::BYTE_W-1:0] m_axis_tdata,   // [7:0] result_byte
  output logic                       m_axis_tlast
);

  localparam int W = lkx_pkg::WORD_W;
  localparam int H = lkx_pkg::HALF_W;

  lkx_pkg::state_t             state;
  lkx_pkg::state_t             state_next;
  lkx_pkg::item_t              item;
  logic [W-1:0]                opnd;
  logic [W-1:0]                prod;
  logic [W-1:0]                acc;
  logic [W-1:0]                rem;
  logic [W-1:0]                gen;
  logic [lkx_pkg::STEP_W-1:0]  cnt;
  logic                        at_start;
  logic [H-1:0]                mul_a;
  logic [H-1:0]                mul_b;
  logic [W-1:0]                mul_out;
  logic [W:0]                  shifted;
  logic [W:0]                  diff;
  logic [W-1:0]                rem_step;
  logic                        out_free;
  logic                        load_out;
  logic                        mod_zero;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign mod_zero = (cfg.modulus == '0);

  // Shared 32x32 multiplier, operand halves picked by state
  always_comb begin
    case (state)
      lkx_pkg::ST_MUL_LH: begin
        mul_a = cfg.multiplier[H-1:0];
        mul_b = opnd[W-1:H];
      end
      lkx_pkg::ST_MUL_HL: begin
        mul_a = cfg.multiplier[W-1:H];
        mul_b = opnd[H-1:0];
      end
      default: begin
        mul_a = cfg.multiplier[H-1:0];
        mul_b = opnd[H-1:0];
      end
    endcase
  end
  assign mul_out = {{H{1'b0}}, mul_a} * {{H{1'b0}}, mul_b};

  // One restoring remainder step
  assign shifted  = {rem, acc[W-1]};
  assign diff     = shifted - {1'b0, cfg.modulus};
  assign rem_step = (shifted >= {1'b0, cfg.modulus}) ? diff[W-1:0] : shifted[W-1:0];

  // Next state and handshake outputs
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    case (state)
      lkx_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = lkx_pkg::ST_MUL_LL;
        end
      end
      lkx_pkg::ST_MUL_LL: state_next = lkx_pkg::ST_MUL_LH;
      lkx_pkg::ST_MUL_LH: state_next = lkx_pkg::ST_MUL_HL;
      lkx_pkg::ST_MUL_HL: state_next = lkx_pkg::ST_ADD;
      lkx_pkg::ST_ADD:    state_next = lkx_pkg::ST_INC;
      lkx_pkg::ST_INC: begin
        state_next = mod_zero ? lkx_pkg::ST_FINISH : lkx_pkg::ST_DIV;
      end
      lkx_pkg::ST_DIV: begin
        if (cnt == '0) begin
          state_next = lkx_pkg::ST_FINISH;
        end
      end
      lkx_pkg::ST_FINISH: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = lkx_pkg::ST_IDLE;
        end
      end
      default: state_next = lkx_pkg::ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkx_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: multiply in three partial products, add, then reduce
  always_ff @(posedge clk) begin
    case (state)
      lkx_pkg::ST_IDLE: begin
        if (q_valid) begin
          item <= q_item;
          opnd <= at_start ? cfg.seed : gen;
        end
      end
      lkx_pkg::ST_MUL_LL: prod <= mul_out;
      lkx_pkg::ST_MUL_LH: begin
        acc  <= prod;
        prod <= mul_out;
      end
      lkx_pkg::ST_MUL_HL: begin
        acc  <= acc + {prod[H-1:0], {H{1'b0}}};
        prod <= mul_out;
      end
      lkx_pkg::ST_ADD: acc <= acc + {prod[H-1:0], {H{1'b0}}};
      lkx_pkg::ST_INC: begin
        if (mod_zero) begin
          rem <= acc + cfg.increment;
        end else begin
          acc <= acc + cfg.increment;
          rem <= '0;
          cnt <= '1;
        end
      end
      lkx_pkg::ST_DIV: begin
        rem <= rem_step;
        acc <= {acc[W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Commit the generator value and fill the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      gen           <= '0;
      at_start      <= 1'b1;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        gen           <= rem;
        at_start      <= item.last;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= item.data_byte ^ (rem[lkx_pkg::BYTE_W-1:0] & lkx_pkg::PAD_MASK);
      m_axis_tlast <= item.last;
    end
  end

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == lkx_pkg::ST_MUL_LL))
    else $error("pop did not start a generator step");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == lkx_pkg::ST_DIV && cnt == '0) |=> (state == lkx_pkg::ST_FINISH))
    else $error("remainder pass did not end after its last step");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == lkx_pkg::ST_FINISH))
    else $error("output valid rose outside the finish step");

  a_start_tracks_last: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (at_start == $past(item.last)))
    else $error("message start flag does not follow last");

endmodule
